// File: hdl/dual_stack_max_top_store_assert.svh
// Assertion macros for the dual stack store.
// Expects clk and arst_n in the scope where the macros are used.
`ifndef DUAL_STACK_MAX_TOP_STORE_ASSERT_SVH
`define DUAL_STACK_MAX_TOP_STORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DSMTS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define DSMTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/dsmts_pkg.sv
// Shared types and constants for the dual stack store.
// No dependencies.
package dsmts_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned COUNT_W = 7;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STS_DONE  = 2'd0,
		STS_FULL  = 2'd1,
		STS_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		SIDE_LOW  = 1'b0,
		SIDE_HIGH = 1'b1
	} side_t;

	typedef enum logic {
		S_IDLE,
		S_POP_WAIT
	} state_t;

endpackage

// File: hdl/dsmts_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module dsmts_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

// File: hdl/dual_stack_max_top_store.sv
// Top level of the dual stack store: control, cached tops, result register.
// Depends on dsmts_pkg, dsmts_ram and dual_stack_max_top_store_assert.svh.

// Two stacks share one RAM of DEPTH words: the low stack grows up from entry 0, the
// high stack down from entry DEPTH-1. A push goes to the low stack when it is empty or
// when the high stack is in use and its top is at least the low top, else to the high
// stack; a pop takes the larger top (low on a tie). The top of each stack is cached in
// a register, so a push, a refused item, or a pop that empties its stack completes
// straight from S_IDLE; a pop that leaves entries behind passes through S_POP_WAIT,
// since the new top is fetched through the single RAM port, whose read is registered.
// One item is in flight at a time; a finished result waits in the output register and
// the next item is taken while it is read out. No clearing pass after reset: RAM
// entries are only read after being pushed. Counts are reported modulo 128.
`include "dual_stack_max_top_store_assert.svh"

module dual_stack_max_top_store #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            cmd,
	input  logic signed [31:0]              value,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      status,
	output logic                            side,
	output logic signed [31:0]              removed_value,
	output logic signed [31:0]              max_top,
	output logic [6:0]                      low_count,
	output logic [6:0]                      high_count
);

	import dsmts_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	state_t                   state_q, state_d;
	logic [CW-1:0]            low_cnt_q, low_cnt_d;
	logic [CW-1:0]            high_cnt_q, high_cnt_d;
	logic signed [DATA_W-1:0] low_top_q, low_top_d;
	logic signed [DATA_W-1:0] high_top_q, high_top_d;
	side_t                    pop_side_q;
	logic signed [DATA_W-1:0] pop_removed_q;

	logic                     out_valid_q;
	status_t                  status_q;
	side_t                    side_q;
	logic signed [DATA_W-1:0] removed_q;
	logic signed [DATA_W-1:0] max_top_q;
	logic [COUNT_W-1:0]       low_count_q, high_count_q;

	logic                     accept, finish, full, empty, high_ge_low, low_ge_high;
	logic                     ram_en, ram_we;
	logic [AW-1:0]            ram_addr;
	logic [DATA_W-1:0]        ram_rdata;
	logic [CW:0]              cnt_sum;
	logic [CW-1:0]            low_rd_idx;
	logic [CW:0]              high_rd_idx;
	logic [CW+COUNT_W-1:0]    low_cnt_ext, high_cnt_ext;

	status_t                  res_status;
	side_t                    res_side;
	logic signed [DATA_W-1:0] res_removed;
	logic signed [DATA_W-1:0] res_max;

	dsmts_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (value),
		.rdata (ram_rdata)
	);

	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	assign cnt_sum     = {1'b0, low_cnt_q} + {1'b0, high_cnt_q};
	assign full        = cnt_sum >= (CW+1)'(DEPTH);
	assign empty       = (low_cnt_q == '0) && (high_cnt_q == '0);
	assign high_ge_low = high_top_q >= low_top_q;
	assign low_ge_high = low_top_q >= high_top_q;

	// address of the entry that becomes the new top after a pop
	assign low_rd_idx  = low_cnt_q - CW'(2);
	assign high_rd_idx = (CW+1)'(DEPTH + 1) - {1'b0, high_cnt_q};

	always_comb begin
		state_d     = state_q;
		low_cnt_d   = low_cnt_q;
		high_cnt_d  = high_cnt_q;
		low_top_d   = low_top_q;
		high_top_d  = high_top_q;
		ram_en      = 1'b0;
		ram_we      = 1'b0;
		ram_addr    = low_cnt_q[AW-1:0];
		finish      = 1'b0;
		res_status  = STS_DONE;
		res_side    = SIDE_LOW;
		res_removed = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd_t'(cmd) == CMD_PUSH) begin
						finish = 1'b1;
						if (full) begin
							res_status = STS_FULL;
						end else if ((low_cnt_q == '0) ||
								((high_cnt_q != '0) && high_ge_low)) begin
							ram_en    = 1'b1;
							ram_we    = 1'b1;
							ram_addr  = low_cnt_q[AW-1:0];
							low_cnt_d = low_cnt_q + CW'(1);
							low_top_d = value;
						end else begin
							ram_en     = 1'b1;
							ram_we     = 1'b1;
							ram_addr   = LAST_ADDR - high_cnt_q[AW-1:0];
							high_cnt_d = high_cnt_q + CW'(1);
							high_top_d = value;
							res_side   = SIDE_HIGH;
						end
					end else begin
						if (empty) begin
							finish     = 1'b1;
							res_status = STS_EMPTY;
						end else if ((high_cnt_q == '0) ||
								((low_cnt_q != '0) && low_ge_high)) begin
							low_cnt_d   = low_cnt_q - CW'(1);
							res_removed = low_top_q;
							if (low_cnt_q == CW'(1)) begin
								finish = 1'b1;
							end else begin
								ram_en   = 1'b1;
								ram_addr = low_rd_idx[AW-1:0];
								state_d  = S_POP_WAIT;
							end
						end else begin
							high_cnt_d  = high_cnt_q - CW'(1);
							res_removed = high_top_q;
							res_side    = SIDE_HIGH;
							if (high_cnt_q == CW'(1)) begin
								finish = 1'b1;
							end else begin
								ram_en   = 1'b1;
								ram_addr = high_rd_idx[AW-1:0];
								state_d  = S_POP_WAIT;
							end
						end
					end
				end
			end
			S_POP_WAIT: begin
				// new top of the popped stack arrives from the RAM
				finish      = 1'b1;
				res_side    = pop_side_q;
				res_removed = pop_removed_q;
				state_d     = S_IDLE;
				if (pop_side_q == SIDE_LOW) begin
					low_top_d = ram_rdata;
				end else begin
					high_top_d = ram_rdata;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if ((low_cnt_d == '0) && (high_cnt_d == '0)) begin
			res_max = '0;
		end else if (low_cnt_d == '0) begin
			res_max = high_top_d;
		end else if (high_cnt_d == '0) begin
			res_max = low_top_d;
		end else if (high_top_d >= low_top_d) begin
			res_max = high_top_d;
		end else begin
			res_max = low_top_d;
		end
	end

	assign low_cnt_ext  = {{COUNT_W{1'b0}}, low_cnt_d};
	assign high_cnt_ext = {{COUNT_W{1'b0}}, high_cnt_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			low_cnt_q   <= '0;
			high_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			low_cnt_q  <= low_cnt_d;
			high_cnt_q <= high_cnt_d;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		low_top_q  <= low_top_d;
		high_top_q <= high_top_d;
		if (state_d == S_POP_WAIT && state_q == S_IDLE) begin
			pop_side_q    <= res_side;
			pop_removed_q <= res_removed;
		end
		if (finish) begin
			status_q     <= res_status;
			side_q       <= res_side;
			removed_q    <= res_removed;
			max_top_q    <= res_max;
			low_count_q  <= low_cnt_ext[COUNT_W-1:0];
			high_count_q <= high_cnt_ext[COUNT_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign side          = side_q;
	assign removed_value = removed_q;
	assign max_top       = max_top_q;
	assign low_count     = low_count_q;
	assign high_count    = high_count_q;

	`DSMTS_ASSERT_NOW(a_no_overfill, 1'b1, cnt_sum <= (CW+1)'(DEPTH),
		"stacks hold more entries than the store")
	`DSMTS_ASSERT_NOW(a_wait_slot_free, state_q == S_POP_WAIT, !out_valid_q,
		"result register busy while a pop waits on the store")
	`DSMTS_ASSERT_NEXT(a_wait_completes, state_q == S_POP_WAIT,
		(state_q == S_IDLE) && out_valid_q, "pop did not complete after store read")
	`DSMTS_ASSERT_NOW(a_full_consistent, out_valid_q && (status_q == STS_FULL),
		cnt_sum == (CW+1)'(DEPTH), "full reported while the store has room")

endmodule

// File: tb/sv/tb_dual_stack_max_top_store.sv
`timescale 1ns / 100ps
// Testbench for dual_stack_max_top_store: directed and random push/pop beats with
// random gaps and output stalls, each result checked against a local stack predictor.
// Depends on dsmts_pkg and the dual_stack_max_top_store RTL.
module tb_dual_stack_max_top_store;
	import dsmts_pkg::*;

	localparam int unsigned DEPTH = 64;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

	typedef struct {
		status_t            status;
		side_t              side;
		logic signed [31:0] removed_value;
		logic signed [31:0] max_top;
		logic [6:0]         low_count;
		logic [6:0]         high_count;
	} stack_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	cmd_t               cmd = CMD_PUSH;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic               side;
	logic signed [31:0] removed_value;
	logic signed [31:0] max_top;
	logic [6:0]         low_count;
	logic [6:0]         high_count;

	// predictor state
	logic signed [31:0] shadow_store [DEPTH];
	int unsigned        shadow_low = 0;
	int unsigned        shadow_high = 0;

	stack_result_t      pending_results [$];
	int unsigned        err_count = 0;
	bit                 sender_gaps_on = 1'b1;

	int unsigned        stall_left = 0;
	int unsigned        free_left = 0;

	dual_stack_max_top_store #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.side         (side),
		.removed_value(removed_value),
		.max_top      (max_top),
		.low_count    (low_count),
		.high_count   (high_count)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic stack_result_t predict_stack_result(cmd_t c, logic signed [31:0] v);
		stack_result_t      r;
		logic signed [31:0] lt;
		logic signed [31:0] ht;
		bit                 take_low;
		r.status        = STS_DONE;
		r.side          = SIDE_LOW;
		r.removed_value = '0;
		lt = (shadow_low != 0) ? shadow_store[shadow_low - 1] : '0;
		ht = (shadow_high != 0) ? shadow_store[DEPTH - shadow_high] : '0;
		if (c == CMD_PUSH) begin
			if (shadow_low + shadow_high >= DEPTH) begin
				r.status = STS_FULL;
			end else begin
				// empty low stack wins; empty high stack (with low in use) takes it
				take_low = (shadow_low == 0) || (shadow_high != 0 && ht >= lt);
				if (take_low) begin
					shadow_store[shadow_low] = v;
					shadow_low++;
				end else begin
					shadow_high++;
					shadow_store[DEPTH - shadow_high] = v;
					r.side = SIDE_HIGH;
				end
			end
		end else begin
			if (shadow_low == 0 && shadow_high == 0) begin
				r.status = STS_EMPTY;
			end else begin
				take_low = (shadow_high == 0) || (shadow_low != 0 && lt >= ht);
				if (take_low) begin
					r.removed_value = lt;
					shadow_low--;
				end else begin
					r.removed_value = ht;
					shadow_high--;
					r.side = SIDE_HIGH;
				end
			end
		end
		lt = (shadow_low != 0) ? shadow_store[shadow_low - 1] : '0;
		ht = (shadow_high != 0) ? shadow_store[DEPTH - shadow_high] : '0;
		if (shadow_low == 0)
			r.max_top = ht;
		else if (shadow_high == 0)
			r.max_top = lt;
		else
			r.max_top = (ht >= lt) ? ht : lt;
		r.low_count  = shadow_low[6:0];
		r.high_count = shadow_high[6:0];
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap(int unsigned zero_pct);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < zero_pct)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 24);
	endfunction

	task automatic send_stack_op(cmd_t c, logic signed [31:0] v);
		int unsigned gap;
		gap = sender_gaps_on ? pick_gap(60) : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		value    <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(predict_stack_result(c, v));
	endtask

	task automatic compare_field(string name, logic signed [31:0] exp, logic signed [31:0] act);
		if (act !== exp) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp, act);
			err_count++;
		end
	endtask

	// output stall: short runs, occasional long runs, and calm stretches
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (free_left != 0) begin
			out_stall <= 1'b0;
			free_left--;
		end else begin
			out_stall <= 1'b0;
			if ($urandom_range(0, 99) < 8) begin
				free_left = $urandom_range(20, 80);
			end else begin
				free_left  = $urandom_range(0, 4);
				stall_left = pick_gap(0);
			end
		end
	end

	always @(posedge clk) begin
		stack_result_t exp;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no expectation pending");
				err_count++;
			end else begin
				exp = pending_results.pop_front();
				compare_field("status", 32'(exp.status), 32'(status));
				compare_field("side", 32'(exp.side), 32'(side));
				compare_field("removed_value", exp.removed_value, removed_value);
				compare_field("max_top", exp.max_top, max_top);
				compare_field("low_count", 32'(exp.low_count), 32'(low_count));
				compare_field("high_count", 32'(exp.high_count), 32'(high_count));
			end
		end
	end

	task automatic test_empty_and_first_pushes();
		send_stack_op(CMD_POP, 32'sd123);      // pop on empty store
		send_stack_op(CMD_PUSH, VAL_MIN);      // both empty: goes low
		send_stack_op(CMD_PUSH, VAL_MAX);      // high empty: goes high
		send_stack_op(CMD_PUSH, 32'sd0);
		send_stack_op(CMD_PUSH, -32'sd1);
		send_stack_op(CMD_POP, '0);
		send_stack_op(CMD_POP, '0);
		send_stack_op(CMD_POP, '0);
		send_stack_op(CMD_POP, '0);
		send_stack_op(CMD_POP, '0);
	endtask

	task automatic test_ties_and_extremes();
		send_stack_op(CMD_PUSH, 32'sd5);
		send_stack_op(CMD_PUSH, 32'sd5);
		send_stack_op(CMD_PUSH, 32'sd9);       // equal tops: low
		send_stack_op(CMD_POP, '0);
		send_stack_op(CMD_POP, '0);            // equal tops: low
		send_stack_op(CMD_POP, '0);
		send_stack_op(CMD_PUSH, VAL_MAX);
		send_stack_op(CMD_PUSH, VAL_MIN);
		send_stack_op(CMD_PUSH, 32'sd0);       // high top below low top: high
		send_stack_op(CMD_PUSH, -32'sd1);
		send_stack_op(CMD_POP, '0);
		send_stack_op(CMD_POP, '0);
		send_stack_op(CMD_POP, '0);
		send_stack_op(CMD_POP, '0);
		send_stack_op(CMD_POP, '0);
	endtask

	task automatic test_fill_and_drain();
		for (int i = 0; i < DEPTH + 2; i++)
			send_stack_op(CMD_PUSH, $urandom());
		for (int i = 0; i < DEPTH + 2; i++)
			send_stack_op(CMD_POP, $urandom());
	endtask

	task automatic test_random_ops(int unsigned n_items);
		int unsigned        sent;
		int unsigned        phase_len;
		int unsigned        push_pct;
		int unsigned        r;
		logic signed [31:0] v;
		cmd_t               c;
		sent = 0;
		while (sent < n_items) begin
			phase_len = $urandom_range(20, 120);
			r = $urandom_range(0, 2);
			push_pct = (r == 0) ? 85 : (r == 1) ? 15 : 50;
			sender_gaps_on = ($urandom_range(0, 99) >= 20);
			for (int i = 0; i < phase_len && sent < n_items; i++) begin
				c = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
				r = $urandom_range(0, 99);
				if (r < 40) begin
					v = $signed($urandom_range(0, 8)) - 32'sd4;   // narrow range, many ties
				end else if (r < 50) begin
					case ($urandom_range(0, 3))
						0: v = VAL_MIN;
						1: v = VAL_MAX;
						2: v = 32'sd0;
						default: v = -32'sd1;
					endcase
				end else begin
					v = $urandom();
				end
				send_stack_op(c, v);
				sent++;
			end
		end
		sender_gaps_on = 1'b1;
	endtask

	initial begin
		int unsigned waited;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_first_pushes();
		test_ties_and_extremes();
		test_fill_and_drain();
		test_random_ops(1600);

		@(negedge clk);
		in_valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			err_count++;
		end

		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
